// ===== hw/rtl/jss_pkg.sv =====
// Shared definitions for the jump search table: operation codes, micro-op and
// jump-condition codes, the control word and the datapath status struct.
// No dependencies.
package jss_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int KEY_IN_W        = 32;
    localparam int OPER_W          = 2;

    localparam logic [OPER_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OPER_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OPER_W-1:0] OP_SEARCH = 2'd2;

    localparam int PC_W   = 4;
    localparam int UOP_W  = 4;
    localparam int COND_W = 4;

    localparam logic [PC_W-1:0] PC_IDLE = 4'd0;

    // datapath micro-ops
    localparam logic [UOP_W-1:0] UOP_NOP         = 4'd0;
    localparam logic [UOP_W-1:0] UOP_LATCH       = 4'd1;
    localparam logic [UOP_W-1:0] UOP_CLEAR       = 4'd2;
    localparam logic [UOP_W-1:0] UOP_APPEND      = 4'd3;
    localparam logic [UOP_W-1:0] UOP_EMIT_COUNT  = 4'd4;
    localparam logic [UOP_W-1:0] UOP_SQ_INIT     = 4'd5;
    localparam logic [UOP_W-1:0] UOP_SQ_STEP     = 4'd6;
    localparam logic [UOP_W-1:0] UOP_READ        = 4'd7;
    localparam logic [UOP_W-1:0] UOP_ADV_IF_LESS = 4'd8;
    localparam logic [UOP_W-1:0] UOP_BACK        = 4'd9;
    localparam logic [UOP_W-1:0] UOP_SCAN_STEP   = 4'd10;
    localparam logic [UOP_W-1:0] UOP_EMIT_SEARCH = 4'd11;

    // jump conditions: jump to target when true, else fall through
    localparam logic [COND_W-1:0] COND_NEVER    = 4'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS   = 4'd1;
    localparam logic [COND_W-1:0] COND_NSTART   = 4'd2;
    localparam logic [COND_W-1:0] COND_OP_CLR   = 4'd3;
    localparam logic [COND_W-1:0] COND_OP_APP   = 4'd4;
    localparam logic [COND_W-1:0] COND_OP_SRCH  = 4'd5;
    localparam logic [COND_W-1:0] COND_CNT_ZERO = 4'd6;
    localparam logic [COND_W-1:0] COND_NSQ_LAST = 4'd7;
    localparam logic [COND_W-1:0] COND_CUR_GE_N = 4'd8;
    localparam logic [COND_W-1:0] COND_LESS     = 4'd9;
    localparam logic [COND_W-1:0] COND_SCAN_END = 4'd10;

    typedef struct packed {
        logic              busy;
        logic [UOP_W-1:0]  uop;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } ucode_t;

    typedef struct packed {
        logic [OPER_W-1:0] op;
        logic              cnt_zero;
        logic              sq_last;
        logic              cur_ge_n;
        logic              less;
        logic              scan_end;
    } dp_status_t;

endpackage

// ===== hw/rtl/jump_search_sorted_table.sv =====
// Jump search over a sorted key table; microcoded step sequencer on top level.
// Clear, append, no-op: result strobe in the 3rd, 4th, 5th cycle after the start transfer.
// Search: 9 to 11 + ceil(log2(TABLE_DEPTH+1)/2) + 2*(jumps + scan steps) cycles, up to 78
// at depth 256; each memory probe costs two program steps (registered read). Empty table: 6.
// One item at a time; busy is high from the cycle after the start transfer until the
// strobe cycle, where the next transfer can be taken; done is a one-cycle strobe, no stall.
// rst_n is asynchronous: empties the table and returns the sequencer to idle.
module jump_search_sorted_table #(
    parameter int TABLE_DEPTH = jss_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = jss_pkg::DEF_KEY_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [jss_pkg::OPER_W-1:0]            operation,
    input  logic [jss_pkg::KEY_IN_W-1:0]          key_value,
    output logic                                  done,
    output logic                                  found,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]      position,
    output logic                                  table_full
);
    import jss_pkg::*;

    logic [PC_W-1:0] pc_reg, pc_next;
    ucode_t          uword;
    dp_status_t      status;
    logic            take_jump;

    jss_ucode_rom u_rom (
        .pc    (pc_reg),
        .uword (uword)
    );

    jss_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .uop        (uword.uop),
        .operation  (operation),
        .key_value  (key_value),
        .status     (status),
        .done       (done),
        .found      (found),
        .position   (position),
        .table_full (table_full)
    );

    always_comb
    begin
        case (uword.cond)
            COND_NEVER:    take_jump = 1'b0;
            COND_ALWAYS:   take_jump = 1'b1;
            COND_NSTART:   take_jump = !start;
            COND_OP_CLR:   take_jump = status.op == OP_CLEAR;
            COND_OP_APP:   take_jump = status.op == OP_APPEND;
            COND_OP_SRCH:  take_jump = status.op == OP_SEARCH;
            COND_CNT_ZERO: take_jump = status.cnt_zero;
            COND_NSQ_LAST: take_jump = !status.sq_last;
            COND_CUR_GE_N: take_jump = status.cur_ge_n;
            COND_LESS:     take_jump = status.less;
            COND_SCAN_END: take_jump = status.scan_end;
            default:       take_jump = 1'b1;
        endcase
        pc_next = take_jump ? uword.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign busy = uword.busy;

endmodule

// ===== hw/rtl/jss_ucode_rom.sv =====
// Control store: one control word per program step.
// Depends on jss_pkg.
module jss_ucode_rom (
    input  logic [jss_pkg::PC_W-1:0] pc,
    output jss_pkg::ucode_t          uword
);
    import jss_pkg::*;

    localparam logic [PC_W-1:0] A_IDLE   = PC_IDLE;
    localparam logic [PC_W-1:0] A_NOOP   = 4'd4;
    localparam logic [PC_W-1:0] A_CLR    = 4'd5;
    localparam logic [PC_W-1:0] A_APP    = 4'd6;
    localparam logic [PC_W-1:0] A_SRCH   = 4'd7;
    localparam logic [PC_W-1:0] A_SQRT   = 4'd8;
    localparam logic [PC_W-1:0] A_JREAD  = 4'd9;
    localparam logic [PC_W-1:0] A_BACK   = 4'd11;
    localparam logic [PC_W-1:0] A_SREAD  = 4'd12;
    localparam logic [PC_W-1:0] A_EMIT   = 4'd14;

    function automatic ucode_t mk(input logic b, input logic [UOP_W-1:0] u,
                                  input logic [COND_W-1:0] c, input logic [PC_W-1:0] t);
        ucode_t w;
        w.busy   = b;
        w.uop    = u;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    always_comb
    begin
        case (pc)
            4'd0:    uword = mk(1'b0, UOP_LATCH,       COND_NSTART,   A_IDLE);
            4'd1:    uword = mk(1'b1, UOP_NOP,         COND_OP_CLR,   A_CLR);
            4'd2:    uword = mk(1'b1, UOP_NOP,         COND_OP_APP,   A_APP);
            4'd3:    uword = mk(1'b1, UOP_NOP,         COND_OP_SRCH,  A_SRCH);
            4'd4:    uword = mk(1'b1, UOP_EMIT_COUNT,  COND_ALWAYS,   A_IDLE);
            4'd5:    uword = mk(1'b1, UOP_CLEAR,       COND_ALWAYS,   A_IDLE);
            4'd6:    uword = mk(1'b1, UOP_APPEND,      COND_ALWAYS,   A_IDLE);
            4'd7:    uword = mk(1'b1, UOP_SQ_INIT,     COND_CNT_ZERO, A_NOOP);
            4'd8:    uword = mk(1'b1, UOP_SQ_STEP,     COND_NSQ_LAST, A_SQRT);
            4'd9:    uword = mk(1'b1, UOP_READ,        COND_CUR_GE_N, A_BACK);
            4'd10:   uword = mk(1'b1, UOP_ADV_IF_LESS, COND_LESS,     A_JREAD);
            4'd11:   uword = mk(1'b1, UOP_BACK,        COND_NEVER,    A_IDLE);
            4'd12:   uword = mk(1'b1, UOP_READ,        COND_SCAN_END, A_EMIT);
            4'd13:   uword = mk(1'b1, UOP_SCAN_STEP,   COND_LESS,     A_SREAD);
            4'd14:   uword = mk(1'b1, UOP_EMIT_SEARCH, COND_ALWAYS,   A_IDLE);
            default: uword = mk(1'b1, UOP_NOP,         COND_ALWAYS,   A_IDLE);
        endcase
    end

endmodule

// ===== hw/rtl/jss_datapath.sv =====
// Datapath: key memory, entry count, square-root step unit, probe pointer and
// result registers, driven by one micro-op per cycle. Depends on jss_pkg.
module jss_datapath #(
    parameter int TABLE_DEPTH = jss_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = jss_pkg::DEF_KEY_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [jss_pkg::UOP_W-1:0]             uop,
    input  logic [jss_pkg::OPER_W-1:0]            operation,
    input  logic [jss_pkg::KEY_IN_W-1:0]          key_value,
    output jss_pkg::dp_status_t                   status,
    output logic                                  done,
    output logic                                  found,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]      position,
    output logic                                  table_full
);
    import jss_pkg::*;

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CUR_W  = CNT_W + 1;
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SQ_W   = (CNT_W + 1) / 2;
    localparam logic [SQ_W-1:0]  SQ_TOP   = SQ_W'(1) << (SQ_W - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

    logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];

    logic [OPER_W-1:0]    op_reg;
    logic [KEY_WIDTH-1:0] key_reg, key_next, rd_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CUR_W-1:0]     cur_reg, cur_next;
    logic [SQ_W-1:0]      root_reg, root_next, sqbit_reg, sqbit_next, left_reg, left_next;
    logic                 found_reg, found_next, full_reg, full_next, done_reg, done_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;

    logic [KEY_WIDTH+KEY_IN_W-1:0] key_wide;
    logic [SQ_W-1:0]               trial;
    logic [2*SQ_W-1:0]             trial_sq;
    logic                          cur_ge_n, less, mem_we, mem_re;

    assign key_wide = {{KEY_WIDTH{1'b0}}, key_value};
    assign trial    = root_reg | sqbit_reg;
    assign trial_sq = trial * trial;
    assign cur_ge_n = cur_reg >= CUR_W'(cnt_reg);
    assign less     = rd_reg < key_reg;

    assign status.op       = op_reg;
    assign status.cnt_zero = cnt_reg == '0;
    assign status.sq_last  = sqbit_reg[0];
    assign status.cur_ge_n = cur_ge_n;
    assign status.less     = less;
    assign status.scan_end = cur_ge_n || (left_reg == '0);

    assign mem_we = (uop == UOP_APPEND) && (cnt_reg != CNT_FULL);
    assign mem_re = uop == UOP_READ;

    always_comb
    begin
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        root_next  = root_reg;
        sqbit_next = sqbit_reg;
        left_next  = left_reg;
        found_next = 1'b0;
        pos_next   = cnt_reg;
        full_next  = 1'b0;
        done_next  = 1'b0;
        case (uop)
            UOP_LATCH:
            begin
                key_next = key_wide[KEY_WIDTH-1:0];
            end
            UOP_CLEAR:
            begin
                cnt_next  = '0;
                pos_next  = '0;
                done_next = 1'b1;
            end
            UOP_APPEND:
            begin
                done_next = 1'b1;
                if (cnt_reg == CNT_FULL)
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            UOP_EMIT_COUNT:
            begin
                done_next = 1'b1;
            end
            UOP_SQ_INIT:
            begin
                root_next  = '0;
                sqbit_next = SQ_TOP;
                cur_next   = '0;
            end
            UOP_SQ_STEP:
            begin
                // digit-by-digit root: keep the trial bit when trial^2 <= count
                if (trial_sq <= (2*SQ_W)'(cnt_reg))
                begin
                    root_next = trial;
                end
                sqbit_next = sqbit_reg >> 1;
            end
            UOP_ADV_IF_LESS:
            begin
                if (less)
                begin
                    cur_next = cur_reg + CUR_W'(root_reg);
                end
            end
            UOP_BACK:
            begin
                if (cur_reg != '0)
                begin
                    cur_next = cur_reg - CUR_W'(root_reg);
                end
                left_next = root_reg;
            end
            UOP_SCAN_STEP:
            begin
                if (less)
                begin
                    cur_next  = cur_reg + 1'b1;
                    left_next = left_reg - 1'b1;
                end
            end
            UOP_EMIT_SEARCH:
            begin
                // rd_reg holds the entry at cur_reg on either path into this step
                done_next = 1'b1;
                if (!cur_ge_n && (rd_reg == key_reg))
                begin
                    found_next = 1'b1;
                    pos_next   = cur_reg[CNT_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uop == UOP_LATCH)
        begin
            op_reg <= operation;
        end
        key_reg   <= key_next;
        cur_reg   <= cur_next;
        root_reg  <= root_next;
        sqbit_reg <= sqbit_next;
        left_reg  <= left_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
        full_reg  <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= key_reg;
        end
        if (mem_re)
        begin
            rd_reg <= mem[cur_reg[ADDR_W-1:0]];
        end
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign position   = pos_reg;
    assign table_full = full_reg;

endmodule

// ===== hw/rtl/jss_checker.sv =====
// Port-level checks for jump_search_sorted_table, attached by bind.
// Depends on jss_pkg and the top level's ports.
module jss_checker #(
    parameter int POS_W = 9
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [jss_pkg::OPER_W-1:0]     operation,
    input logic [jss_pkg::KEY_IN_W-1:0]   key_value,
    input logic                           done,
    input logic                           found,
    input logic [POS_W-1:0]               position,
    input logic                           table_full
);
    import jss_pkg::*;

    // result appears only once the block is ready again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("no busy or early result after start transfer");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start transfer");

    a_accept_known: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> !$isunknown({operation, key_value}))
        else $error("unknown command fields at start transfer");

    a_found_full: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!$isunknown({found, position, table_full}) && !(found && table_full)))
        else $error("unknown result fields, or found and table_full together");

endmodule

bind jump_search_sorted_table jss_checker #(
    .POS_W ($clog2(TABLE_DEPTH + 1))
) u_jss_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .key_value  (key_value),
    .done       (done),
    .found      (found),
    .position   (position),
    .table_full (table_full)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for jump_search_sorted_table: clear / append / search transfers
// against a behavioral table model. Depends on jss_pkg and the top-level RTL only.
module testbench;
    import jss_pkg::*;

    localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
    localparam int POS_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ITEM_TARGET = 1900;
    localparam int CYCLE_LIMIT = 2000000;

    // no-op code, not defined in the package
    localparam logic [OPER_W-1:0] OP_UNDEF = 2'd3;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             table_full;
    } table_result_t;

    typedef struct {
        logic [OPER_W-1:0]   op;
        logic [KEY_IN_W-1:0] key;
        bit                  typed;
        table_result_t       want;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [OPER_W-1:0]   operation = OP_CLEAR;
    logic [KEY_IN_W-1:0] key_value = '0;
    logic                busy;
    logic                done;
    logic                found;
    logic [POS_W-1:0]    position;
    logic                table_full;

    // shadow copy of the block's table
    logic [KEY_IN_W-1:0] model_keys [TABLE_DEPTH];
    int                  model_count = 0;

    table_result_t pending_results[$];
    stim_row_t     directed_rows[15];
    int            error_count = 0;
    int            items_sent = 0;
    int            cycle_count = 0;

    jump_search_sorted_table u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .key_value  (key_value),
        .done       (done),
        .found      (found),
        .position   (position),
        .table_full (table_full)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Applies one operation to the shadow table and returns what the block should report.
    function automatic table_result_t apply_table_op(logic [OPER_W-1:0] op,
                                                     logic [KEY_IN_W-1:0] key);
        table_result_t r;
        int n, step, cur, left;
        r = '0;
        n = model_count;
        case (op)
            OP_CLEAR:
                model_count = 0;
            OP_APPEND:
            begin
                r.position = POS_W'(n);
                if (n >= TABLE_DEPTH)
                    r.table_full = 1'b1;
                else
                begin
                    model_keys[n] = key;
                    model_count = n + 1;
                end
            end
            OP_SEARCH:
            begin
                if (n != 0)
                begin
                    step = 0;
                    while ((step + 1) * (step + 1) <= n)
                        step++;
                    cur = 0;
                    while (cur < n && model_keys[cur] < key)
                        cur += step;
                    if (cur != 0)
                        cur -= step;
                    left = step;
                    // linear scan stops at the table end without comparing past it
                    while (cur < n && left > 0 && model_keys[cur] < key)
                    begin
                        left--;
                        cur++;
                    end
                    if (cur < n && model_keys[cur] == key)
                    begin
                        r.found = 1'b1;
                        r.position = POS_W'(cur);
                    end
                    else
                        r.position = POS_W'(n);
                end
            end
            default:
                r.position = POS_W'(n);
        endcase
        return r;
    endfunction

    // Drives one command and waits for its transfer; sometimes a random gap before it.
    task automatic issue_op(input logic [OPER_W-1:0] op, input logic [KEY_IN_W-1:0] key,
                            input bit typed, input table_result_t want);
        int            gap;
        bit            no_idle;
        table_result_t res;
        no_idle = (items_sent >= 700 && items_sent < 1000);
        if (!no_idle && $urandom_range(0, 99) < 25)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 90) : $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        key_value <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        res = apply_table_op(op, key);
        pending_results.push_back(typed ? want : res);
        items_sent++;
    endtask

    // clear, fill, then a burst of searches with occasional noise
    task automatic run_sequence(input int fill);
        bit [KEY_IN_W-1:0] keys[$];
        bit [KEY_IN_W-1:0] k;
        int                mode, searches, pick;
        mode = $urandom_range(0, 9);
        issue_op(OP_CLEAR, $urandom, 1'b0, '0);
        for (int i = 0; i < fill; i++)
        begin
            if (mode < 6 || mode == 8)
                k = $urandom;
            else if (mode < 8)
                k = $urandom_range(0, 15);
            else
                k = $urandom_range(0, 1) ? $urandom_range(0, 7) : 32'hFFFF_FFFF - $urandom_range(0, 7);
            keys.push_back(k);
        end
        if (mode != 8)
            keys.sort();
        foreach (keys[i])
            issue_op(OP_APPEND, keys[i], 1'b0, '0);
        searches = $urandom_range(4, 20);
        for (int s = 0; s < searches; s++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                issue_op(OP_UNDEF, $urandom, 1'b0, '0);
            else if (pick < 8)
            begin
                // append that keeps the order when possible
                k = (keys.size() != 0 && mode != 8) ?
                    keys[keys.size() - 1] + $urandom_range(0, 3) : $urandom;
                keys.push_back(k);
                issue_op(OP_APPEND, k, 1'b0, '0);
            end
            else if (pick < 65 && keys.size() != 0)
                issue_op(OP_SEARCH, keys[$urandom_range(0, keys.size() - 1)], 1'b0, '0);
            else if (pick < 85 && keys.size() != 0)
            begin
                k = keys[$urandom_range(0, keys.size() - 1)];
                k = $urandom_range(0, 1) ? k + 1 : k - 1;
                issue_op(OP_SEARCH, k, 1'b0, '0);
            end
            else
                issue_op(OP_SEARCH, $urandom, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result strobe with no transfer outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    error_count++;
                end
                if (position !== want.position)
                begin
                    $error("position: expected %0d, got %0d", want.position, position);
                    error_count++;
                end
                if (table_full !== want.table_full)
                begin
                    $error("table_full: expected %0d, got %0d", want.table_full, table_full);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int fill;
        directed_rows = '{
            '{OP_SEARCH, 32'h0000_0000, 1'b1, '{1'b0, 9'd0, 1'b0}},  // empty table
            '{OP_UNDEF,  32'hFFFF_FFFF, 1'b1, '{1'b0, 9'd0, 1'b0}},
            '{OP_APPEND, 32'h0000_0000, 1'b1, '{1'b0, 9'd0, 1'b0}},
            '{OP_APPEND, 32'h0000_0005, 1'b1, '{1'b0, 9'd1, 1'b0}},
            '{OP_APPEND, 32'h0000_0005, 1'b1, '{1'b0, 9'd2, 1'b0}},
            '{OP_APPEND, 32'h8000_0000, 1'b1, '{1'b0, 9'd3, 1'b0}},
            '{OP_APPEND, 32'hFFFF_FFFF, 1'b1, '{1'b0, 9'd4, 1'b0}},
            '{OP_SEARCH, 32'h0000_0000, 1'b0, '{1'b0, 9'd0, 1'b0}},
            '{OP_SEARCH, 32'h0000_0005, 1'b0, '{1'b0, 9'd0, 1'b0}},
            '{OP_SEARCH, 32'hFFFF_FFFF, 1'b0, '{1'b0, 9'd0, 1'b0}},
            '{OP_SEARCH, 32'hFFFF_FFFE, 1'b0, '{1'b0, 9'd0, 1'b0}},
            '{OP_SEARCH, 32'h0000_0006, 1'b0, '{1'b0, 9'd0, 1'b0}},
            '{OP_UNDEF,  32'h0000_0000, 1'b1, '{1'b0, 9'd5, 1'b0}},
            '{OP_CLEAR,  32'hFFFF_FFFF, 1'b1, '{1'b0, 9'd0, 1'b0}},
            '{OP_SEARCH, 32'h0000_0007, 1'b1, '{1'b0, 9'd0, 1'b0}}
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_op(directed_rows[i].op, directed_rows[i].key,
                     directed_rows[i].typed, directed_rows[i].want);

        // first sequence overfills the table so refused appends get covered early
        fill = TABLE_DEPTH + 2;
        while (items_sent < ITEM_TARGET)
        begin
            run_sequence(fill);
            case ($urandom_range(0, 15))
                0:       fill = 0;
                1, 2:    fill = $urandom_range(200, TABLE_DEPTH + 4);
                default: fill = $urandom_range(1, 40);
            endcase
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
